>>> design/balg_pkg.sv
// Shared constants and types for the battery average level gauge.
// Used by balg_div and battery_average_level_gauge; depends on nothing.
`default_nettype none

package balg_pkg;

  // Averaging window is 2^AVG_SHIFT samples
  localparam int AVG_SHIFT = 9;

  localparam int MV_W    = 13;
  localparam int CNT_W   = AVG_SHIFT + 1;
  localparam int SUM_W   = AVG_SHIFT + 14;
  localparam int LEVEL_W = 8;
  localparam int HALF_W  = 7;
  localparam int DIFF_W  = MV_W - 2;
  localparam int STEP_W  = $clog2(MV_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0]   WINDOW    = CNT_W'(1) << AVG_SHIFT;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(200);

  localparam logic [MV_W-1:0] LOW_POWER_RST = MV_W'(2000);
  localparam logic [MV_W-1:0] SAFETY_RST    = MV_W'(2200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_POWER = 1'b0,
    REG_SAFETY    = 1'b1
  } cfg_reg_e;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/balg_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Divides the running sum by the sample count; depends on balg_pkg.
`default_nettype none

module balg_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [balg_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic [balg_pkg::CNT_W-1:0]  divisor_i,
  output balg_pkg::div_stat_t              stat_o,
  output logic      [balg_pkg::MV_W-1:0]   quotient_o
);

  logic [balg_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [balg_pkg::CNT_W-1:0]  div_q;
  logic [balg_pkg::MV_W-1:0]   dvd_q;
  logic [balg_pkg::MV_W-1:0]   quo_q;
  logic [balg_pkg::STEP_W-1:0] step_q;
  logic                        busy_q;
  logic                        done_q;
  logic [balg_pkg::CNT_W:0]    trial;
  logic                        fits;

  // The quotient is known to fit MV_W bits, so the top CNT_W bits of the
  // dividend seed the remainder and stay below the divisor.
  always_comb begin
    trial = {rem_q, dvd_q[balg_pkg::MV_W-1]};
    fits  = trial >= {1'b0, div_q};
    if (fits) begin
      rem_d = balg_pkg::CNT_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[balg_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == balg_pkg::STEP_W'(balg_pkg::MV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[balg_pkg::MV_W-2:0], 1'b0};
      quo_q <= {quo_q[balg_pkg::MV_W-2:0], fits};
    end else if (start_i) begin
      rem_q <= dividend_i[balg_pkg::SUM_W-1:balg_pkg::MV_W];
      dvd_q <= dividend_i[balg_pkg::MV_W-1:0];
      div_q <= divisor_i;
      quo_q <= '0;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q)
    else $error("divider did not start");

endmodule

`default_nettype wire

>>> design/battery_average_level_gauge.sv
// Top level of the battery average level gauge: sequencer, state and output register.
// Depends on balg_pkg and balg_div.
//
// Usage: a sample transfers on the input channel when in_valid_i and in_ready_o
// are both high. Each sample yields exactly one result on the output channel,
// which transfers when out_valid_o and out_ready_i are both high.
// Path from input transfer to out_valid_o: during warm-up the serial divider
// forms sum / count one quotient bit per cycle, between the accumulate state
// and the output load; once the window is full the average is a shift of
// the sum and the divider is skipped. One sample is in work at a time, so
// the block takes no new sample until the last one's result is loaded.
// in_ready_o is high only while the sequencer is idle.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and its result is held until the receiver frees that register.
// Reset clears the running sum and sample count and loads the thresholds
// with their defaults (2000 mV and 2200 mV). Thresholds are written through
// cfg_we_i / cfg_index_i / cfg_wdata_i; the user must write them only while the block is idle (not enforced).
`default_nettype none

module battery_average_level_gauge (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [balg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [balg_pkg::MV_W-1:0]          cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [balg_pkg::MV_W-1:0]          sample_mv_i,
  input  wire logic                               at_startup_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    low_battery_o,
  output logic      [balg_pkg::MV_W-1:0]          average_mv_o,
  output logic      [balg_pkg::LEVEL_W-1:0]       level_o,
  output logic      [balg_pkg::HALF_W-1:0]        half_level_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                        state_q;
  logic [balg_pkg::MV_W-1:0]     low_power_q;
  logic [balg_pkg::MV_W-1:0]     safety_q;
  logic [balg_pkg::SUM_W-1:0]    sum_q;
  logic [balg_pkg::CNT_W-1:0]    cnt_q;
  logic [balg_pkg::MV_W-1:0]     avg_q;
  logic                          lowb_q;
  logic                          out_valid_q;
  logic                          low_battery_q;
  logic [balg_pkg::MV_W-1:0]     average_q;
  logic [balg_pkg::LEVEL_W-1:0]  level_q;

  logic                          in_xfer;
  logic                          out_free;
  logic                          emit_go;
  logic                          div_start;
  balg_pkg::div_stat_t           div_stat;
  logic [balg_pkg::MV_W-1:0]     div_quo;
  logic [balg_pkg::MV_W-1:0]     threshold;
  logic [balg_pkg::SUM_W-1:0]    shifted;
  logic [balg_pkg::MV_W-1:0]     diff;
  logic [balg_pkg::DIFF_W-1:0]   level_raw;
  logic [balg_pkg::LEVEL_W-1:0]  level_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_go    = (state_q == ST_EMIT) && out_free;
  assign div_start  = (state_q == ST_ACCUM) && (cnt_q != balg_pkg::WINDOW);
  assign threshold  = at_startup_i ? safety_q : low_power_q;
  assign shifted    = sum_q >> balg_pkg::AVG_SHIFT;

  // Level: (average - safety) / 4, zero at or below safety, clamp at full scale
  always_comb begin
    diff      = avg_q - safety_q;
    level_raw = diff[balg_pkg::MV_W-1:2];
    if (avg_q <= safety_q) begin
      level_d = '0;
    end else if (level_raw > balg_pkg::DIFF_W'(balg_pkg::LEVEL_MAX)) begin
      level_d = balg_pkg::LEVEL_MAX;
    end else begin
      level_d = level_raw[balg_pkg::LEVEL_W-1:0];
    end
  end

  balg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      low_power_q   <= balg_pkg::LOW_POWER_RST;
      safety_q      <= balg_pkg::SAFETY_RST;
      sum_q         <= '0;
      cnt_q         <= '0;
      avg_q         <= '0;
      lowb_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      low_battery_q <= 1'b0;
      average_q     <= '0;
      level_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          balg_pkg::REG_LOW_POWER: low_power_q <= cfg_wdata_i;
          balg_pkg::REG_SAFETY:    safety_q    <= cfg_wdata_i;
          default: ;
        endcase
      end

      // Load a new result, or drop the old one once it transfers
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            sum_q   <= sum_q + balg_pkg::SUM_W'(sample_mv_i);
            cnt_q   <= cnt_q + 1'b1;
            lowb_q  <= sample_mv_i < threshold;
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          // Full window: average is a shift, leak it back out of the sum
          if (cnt_q == balg_pkg::WINDOW) begin
            avg_q   <= shifted[balg_pkg::MV_W-1:0];
            sum_q   <= sum_q - shifted;
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            avg_q   <= div_quo;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (out_free) begin
            low_battery_q <= lowb_q;
            average_q     <= avg_q;
            level_q       <= level_d;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign low_battery_o = low_battery_q;
  assign average_mv_o  = average_q;
  assign level_o       = level_q;
  assign half_level_o  = level_q[balg_pkg::LEVEL_W-1:1];

  a_cnt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q < balg_pkg::WINDOW))
    else $error("sample count left the window while idle");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_level_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (level_q <= balg_pkg::LEVEL_MAX))
    else $error("level above full scale");

  a_div_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waiting on an idle divider");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for battery_average_level_gauge: threshold flag, running average, level.
// Drives samples over valid/ready with random idling; each result is predicted or typed in.
// Depends on balg_pkg and the design files only.
`default_nettype none

module tb_top;

  localparam int GAUGE_STEP_MV = 4;
  localparam int MV_TOP        = (1 << balg_pkg::MV_W) - 1;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 128;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_LIMIT   = 30;

  typedef struct packed {
    logic                         low;
    logic [balg_pkg::MV_W-1:0]    avg;
    logic [balg_pkg::LEVEL_W-1:0] level;
    logic [balg_pkg::HALF_W-1:0]  half;
  } gauge_t;

  typedef struct packed {
    logic [balg_pkg::MV_W-1:0] sample;
    logic                      startup;
    logic                      fixed;   // want is typed in, not predicted
    gauge_t                    want;
  } dir_row_t;

  localparam int DIR_N = 18;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{13'd0,    1'b0, 1'b1, '{1'b1, 13'd0,    8'd0,   7'd0}},
    '{13'd8191, 1'b1, 1'b1, '{1'b0, 13'd4095, 8'd200, 7'd100}},
    '{13'd1999, 1'b0, 1'b0, '0},
    '{13'd2000, 1'b0, 1'b0, '0},
    '{13'd2199, 1'b1, 1'b0, '0},
    '{13'd2200, 1'b1, 1'b0, '0},
    '{13'd8191, 1'b0, 1'b0, '0},
    '{13'd0,    1'b1, 1'b0, '0},
    '{13'd1,    1'b0, 1'b0, '0},
    '{13'd4096, 1'b1, 1'b0, '0},
    '{13'd5461, 1'b0, 1'b0, '0},
    '{13'd2730, 1'b1, 1'b0, '0},
    '{13'd2201, 1'b0, 1'b0, '0},
    '{13'd8190, 1'b1, 1'b0, '0},
    '{13'd3000, 1'b0, 1'b0, '0},
    '{13'd0,    1'b0, 1'b0, '0},
    '{13'd8191, 1'b1, 1'b0, '0},
    '{13'd4100, 1'b0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [balg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [balg_pkg::MV_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [balg_pkg::MV_W-1:0] sample_mv_i = '0;
  logic at_startup_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic low_battery_o;
  logic [balg_pkg::MV_W-1:0] average_mv_o;
  logic [balg_pkg::LEVEL_W-1:0] level_o;
  logic [balg_pkg::HALF_W-1:0] half_level_o;

  battery_average_level_gauge dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_mv_i  (sample_mv_i),
    .at_startup_i (at_startup_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .low_battery_o(low_battery_o),
    .average_mv_o (average_mv_o),
    .level_o      (level_o),
    .half_level_o (half_level_o)
  );

  always #4 clk_i = ~clk_i;

  // Predicted gauge state and thresholds
  logic [balg_pkg::SUM_W-1:0] pred_sum = '0;
  logic [balg_pkg::CNT_W-1:0] pred_count = '0;
  logic [balg_pkg::MV_W-1:0]  pred_low_power = balg_pkg::LOW_POWER_RST;
  logic [balg_pkg::MV_W-1:0]  pred_safety = balg_pkg::SAFETY_RST;
  int unsigned                pred_avg = 0;
  bit                         window_full = 1'b0;

  gauge_t result_q[$];
  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int send_idle = 35;
  int recv_idle = 35;
  bit hold_off_req = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  function automatic gauge_t gauge_predict(input logic [balg_pkg::MV_W-1:0] sample,
                                           input logic startup);
    int unsigned acc, cnt, avg, lv;
    logic [balg_pkg::MV_W-1:0] thr;
    gauge_t r;
    acc = pred_sum + sample;
    cnt = pred_count + 1;
    if (cnt >= balg_pkg::WINDOW) begin
      avg = acc >> balg_pkg::AVG_SHIFT;
      acc = acc - avg;
      cnt = cnt - 1;
      window_full = 1'b1;
    end else begin
      avg = acc / cnt;
    end
    avg = avg & MV_TOP;
    pred_sum = balg_pkg::SUM_W'(acc);
    pred_count = balg_pkg::CNT_W'(cnt);
    pred_avg = avg;
    lv = 0;
    if (avg > pred_safety) begin
      lv = (avg - pred_safety) / GAUGE_STEP_MV;
      if (lv > balg_pkg::LEVEL_MAX) lv = balg_pkg::LEVEL_MAX;
    end
    thr = startup ? pred_safety : pred_low_power;
    r.low = (sample < thr);
    r.avg = balg_pkg::MV_W'(avg);
    r.level = balg_pkg::LEVEL_W'(lv);
    r.half = balg_pkg::HALF_W'(lv >> 1);
    return r;
  endfunction

  function automatic logic [balg_pkg::MV_W-1:0] clip_mv(input int v);
    if (v < 0) return '0;
    if (v > MV_TOP) return balg_pkg::MV_W'(MV_TOP);
    return balg_pkg::MV_W'(v);
  endfunction

  // Offer one sample; returns in the step of the accepting edge with valid still high
  task automatic send_sample(input logic [balg_pkg::MV_W-1:0] sample, input logic startup,
                             input logic fixed, input gauge_t want);
    gauge_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_mv_i <= sample;
    at_startup_i <= startup;
    do @(posedge clk_i); while (!in_ready_o);
    pred = gauge_predict(sample, startup);
    result_q.push_back(fixed ? want : pred);
    samples_sent++;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (result_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // Write both thresholds on consecutive edges; block must be idle
  task automatic write_thresholds(input logic [balg_pkg::MV_W-1:0] low_power,
                                  input logic [balg_pkg::MV_W-1:0] safety);
    cfg_we_i <= 1'b1;
    cfg_index_i <= balg_pkg::REG_LOW_POWER;
    cfg_wdata_i <= low_power;
    @(posedge clk_i);
    cfg_index_i <= balg_pkg::REG_SAFETY;
    cfg_wdata_i <= safety;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_low_power = low_power;
    pred_safety = safety;
    settings_used++;
  endtask

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    gauge_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_seen++;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = result_q.pop_front();
        if (low_battery_o !== want.low)
          report_mismatch($sformatf("result %0d low_battery got %0b want %0b",
                                    results_seen, low_battery_o, want.low));
        if (average_mv_o !== want.avg)
          report_mismatch($sformatf("result %0d average_mv got %0d want %0d",
                                    results_seen, average_mv_o, want.avg));
        if (level_o !== want.level)
          report_mismatch($sformatf("result %0d level got %0d want %0d",
                                    results_seen, level_o, want.level));
        if (half_level_o !== want.half)
          report_mismatch($sformatf("result %0d half_level got %0d want %0d",
                                    results_seen, half_level_o, want.half));
      end
    end
  end

  initial begin
    int center, sel, thr_sel;
    logic [balg_pkg::MV_W-1:0] sample, thr, lp, st;
    logic startup;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run on the reset thresholds
    for (int i = 0; i < DIR_N; i++)
      send_sample(DIRECTED[i].sample, DIRECTED[i].startup, DIRECTED[i].fixed, DIRECTED[i].want);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle = 35;
      recv_idle = 35;
      center = int'($urandom_range(1500, 7000));
      case (p)
        1: write_thresholds('0, '0);
        2: write_thresholds(balg_pkg::MV_W'(MV_TOP), balg_pkg::MV_W'(MV_TOP));
        4: write_thresholds(balg_pkg::MV_W'(MV_TOP), '0);
        5: write_thresholds('0, balg_pkg::MV_W'(MV_TOP));
        default: begin
          if (p == 0 || p == 3 || $urandom_range(1)) begin
            // Place the level zero just under the running average so level moves
            st = clip_mv(int'(pred_avg) - int'($urandom_range(0, 900)));
            lp = clip_mv(center + int'($urandom_range(0, 600)) - 300);
          end else begin
            st = balg_pkg::MV_W'($urandom_range(0, MV_TOP));
            lp = balg_pkg::MV_W'($urandom_range(0, MV_TOP));
          end
          write_thresholds(lp, st);
        end
      endcase
      if (p == 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 5) hold_off_req = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        startup = 1'($urandom_range(1));
        thr = startup ? pred_safety : pred_low_power;
        sel = int'($urandom_range(99));
        if (sel < 70) begin
          sample = clip_mv(center + int'($urandom_range(0, 400)) - 200);
        end else if (sel < 85) begin
          sample = balg_pkg::MV_W'($urandom_range(0, MV_TOP));
        end else if (sel < 95) begin
          sample = $urandom_range(1) ? balg_pkg::MV_W'(MV_TOP) : '0;
        end else begin
          thr_sel = int'(thr) + int'($urandom_range(2)) - 1;
          sample = clip_mv(thr_sel);
        end
        send_sample(sample, startup, 1'b0, '0);
      end
      wait_drained();
    end

    // Let any stray result show up before closing
    repeat (40) @(posedge clk_i);
    while (result_q.size() != 0) begin
      void'(result_q.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("covered %0d samples, %0d results, %0d threshold settings, window full: %0b",
             samples_sent, results_seen, settings_used, window_full);
    $display("including a %0d-cycle receiver hold-off and a stretch without idling",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
